// ===== hdl/erq_pkg.sv =====
// Package with the types, widths and codes shared by the extent request aligner.
package erq_pkg;

  localparam int OFF_W     = 54;
  localparam int LEN_W     = 21;
  localparam int ALEN_W    = 23;
  localparam int WIDE_W    = OFF_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RT_EXTENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RT_MODE    = 2'd2;

  localparam logic [1:0] NEXT_NONE    = 2'd0;
  localparam logic [1:0] NEXT_HOLE    = 2'd2;
  localparam logic [1:0] NEXT_DELAYED = 2'd3;

  localparam logic [1:0] PREV_NONE = 2'd0;
  localparam logic [1:0] PREV_HOLE = 2'd2;

  typedef struct packed {
    logic [OFF_W-1:0] req_offset;
    logic [LEN_W-1:0] req_length;
    logic             at_eof;
    logic             delayed_alloc;
    logic             converting;
    logic [1:0]       next_kind;
    logic [OFF_W-1:0] next_offset;
    logic [LEN_W-1:0] next_length;
    logic [1:0]       prev_kind;
    logic [OFF_W-1:0] prev_offset;
    logic [LEN_W-1:0] prev_length;
  } erq_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] aligned_offset;
    logic [LEN_W-1:0] aligned_length;
    logic             status;
  } erq_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCREEN,
    ST_DIV_OFF,
    ST_DIV_LEN,
    ST_DIV_MAX,
    ST_CLAMP_PREV,
    ST_SUM_A,
    ST_CLAMP_NEXT,
    ST_RECLAMP,
    ST_SUM_B,
    ST_TRIM,
    ST_RT_START,
    ST_RT_DIV,
    ST_RT_CHECK,
    ST_RT_ADJUST,
    ST_RT_START2,
    ST_RT_REDIV,
    ST_RT_SUM,
    ST_RT_VERIFY,
    ST_DONE
  } erq_state_t;

endpackage

// ===== hdl/erq_divider.sv =====
// Bit-serial restoring divider that yields the remainder, one dividend bit per cycle.
module erq_divider #(
  parameter int DW = 54,
  parameter int VW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] r_r, r_nxt;
  logic [VW-1:0] d_r, d_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {r_r, q_r[DW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      r_nxt   = (trial >= {1'b0, d_r}) ? diff[VW-1:0] : trial[VW-1:0];
      q_nxt   = {q_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done      = done_r;
  assign remainder = r_r;

endmodule

// ===== hdl/extent_request_aligner.sv =====
// Top level of the extent request aligner: configuration, sequencer and output register.
//
// One request item enters on in_valid/in_ready together with its previous and
// next neighbor extents; one result item leaves on out_valid/out_ready with the
// aligned offset, the aligned length and a status bit (1 when a realtime
// request can no longer be covered). The block works on one item at a time:
// in_ready is high only while the sequencer is idle.
// Latency is set by a shared bit-serial remainder unit. A converted or in-place
// request skips the remainder unit, an ordinary request needs two remainders
// or three, and a realtime request at most five. The next item can be accepted
// in the same cycle as its result appears in the output register.
// Results wait in an output register; a finished item waits for it there, so
// a stalled receiver holds the block after at most one further item.
// Configuration writes on cfg_we take effect at the next clock edge and must
// be made while the block is idle. A synchronous reset on rst_n returns the
// sequencer to idle, drops out_valid and loads align_size = 1,
// rt_extent_size = 1 and realtime_mode = 0. No clearing pass is needed.
module extent_request_aligner #(
  parameter int unsigned MAX_EXTENT_LEN = 2097151
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  erq_pkg::erq_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output erq_pkg::erq_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [erq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [erq_pkg::LEN_W-1:0]         cfg_wdata
);

  import erq_pkg::*;

  localparam logic [ALEN_W-1:0] MAX_LEN = ALEN_W'(MAX_EXTENT_LEN);

  erq_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  align_size_r, rt_size_r;
  logic              rt_mode_r;
  erq_in_t           in_r, in_nxt;
  logic [WIDE_W-1:0] oend_r, oend_nxt;
  logic [WIDE_W-1:0] nend_r, nend_nxt;
  logic [WIDE_W-1:0] prevo_r, prevo_nxt;
  logic [WIDE_W-1:0] nexto_r, nexto_nxt;
  logic              has_next_r, has_next_nxt;
  logic [WIDE_W-1:0] aoff_r, aoff_nxt;
  logic [ALEN_W-1:0] alen_r, alen_nxt;
  logic [WIDE_W-1:0] end_r, end_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              keep_r, keep_nxt;
  logic              fail_r, fail_nxt;
  logic              out_valid_r, out_valid_nxt;
  erq_out_t          out_data_r, out_data_nxt;

  logic              div_start;
  logic [OFF_W-1:0]  div_dividend;
  logic [LEN_W-1:0]  div_divisor;
  logic              div_done;
  logic [LEN_W-1:0]  div_rem;

  logic [LEN_W-1:0]  ext, rte;
  logic [WIDE_W-1:0] ooff_w, olen_w, alen_w, rem_w, div_rem_w;
  logic [ALEN_W-1:0] alen_sum, alen_up;
  logic              inside_next, past_next;

  assign ext       = (align_size_r == '0) ? LEN_W'(1) : align_size_r;
  assign rte       = (rt_size_r == '0) ? LEN_W'(1) : rt_size_r;
  assign ooff_w    = WIDE_W'(in_r.req_offset);
  assign olen_w    = WIDE_W'(in_r.req_length);
  assign alen_w    = WIDE_W'(alen_r);
  assign rem_w     = WIDE_W'(rem_r);
  assign div_rem_w = WIDE_W'(div_rem);
  assign alen_sum  = ALEN_W'(in_r.req_length) + ALEN_W'(div_rem);
  assign alen_up   = (div_rem == '0) ? alen_r :
                     alen_r + ALEN_W'(ext) - ALEN_W'(div_rem);
  assign inside_next = !in_r.delayed_alloc && !in_r.at_eof &&
                       (in_r.next_kind != NEXT_NONE) &&
                       (in_r.req_offset >= in_r.next_offset) && (oend_r <= nend_r);
  assign past_next = has_next_r && (end_r != oend_r) && (end_r > nexto_r);

  erq_divider #(
    .DW(OFF_W),
    .VW(LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    oend_nxt      = oend_r;
    nend_nxt      = nend_r;
    prevo_nxt     = prevo_r;
    nexto_nxt     = nexto_r;
    has_next_nxt  = has_next_r;
    aoff_nxt      = aoff_r;
    alen_nxt      = alen_r;
    end_nxt       = end_r;
    rem_nxt       = rem_r;
    keep_nxt      = keep_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    div_start     = 1'b0;
    div_dividend  = in_r.req_offset;
    div_divisor   = ext;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        oend_nxt     = ooff_w + olen_w;
        nend_nxt     = WIDE_W'(in_r.next_offset) + WIDE_W'(in_r.next_length);
        has_next_nxt = !in_r.at_eof && (in_r.next_kind != NEXT_NONE);
        case (in_r.prev_kind)
          PREV_NONE: prevo_nxt = '0;
          PREV_HOLE: prevo_nxt = WIDE_W'(in_r.prev_offset);
          default:   prevo_nxt = WIDE_W'(in_r.prev_offset) + WIDE_W'(in_r.prev_length);
        endcase
        state_nxt = ST_SCREEN;
      end
      ST_SCREEN: begin
        if ((in_r.delayed_alloc && in_r.next_kind == NEXT_HOLE) ||
            (!in_r.delayed_alloc && in_r.next_kind == NEXT_DELAYED)) begin
          nexto_nxt = nend_r;
        end else begin
          nexto_nxt = WIDE_W'(in_r.next_offset);
        end
        fail_nxt = 1'b0;
        if (in_r.converting || inside_next) begin
          keep_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          keep_nxt  = 1'b0;
          div_start = 1'b1;
          state_nxt = ST_DIV_OFF;
        end
      end
      ST_DIV_OFF: begin
        if (div_done) begin
          aoff_nxt     = ooff_w - div_rem_w;
          alen_nxt     = alen_sum;
          div_start    = 1'b1;
          div_dividend = OFF_W'(alen_sum);
          state_nxt    = ST_DIV_LEN;
        end
      end
      ST_DIV_LEN: begin
        if (div_done) begin
          if (alen_up > MAX_LEN) begin
            div_start    = 1'b1;
            div_dividend = OFF_W'(MAX_LEN);
            state_nxt    = ST_DIV_MAX;
          end else begin
            alen_nxt  = alen_up;
            state_nxt = ST_CLAMP_PREV;
          end
        end
      end
      ST_DIV_MAX: begin
        if (div_done) begin
          alen_nxt  = MAX_LEN - ALEN_W'(div_rem);
          state_nxt = ST_CLAMP_PREV;
        end
      end
      ST_CLAMP_PREV: begin
        if (aoff_r != ooff_w && aoff_r < prevo_r) begin
          aoff_nxt = prevo_r;
        end
        state_nxt = ST_SUM_A;
      end
      ST_SUM_A: begin
        end_nxt   = aoff_r + alen_w;
        state_nxt = ST_CLAMP_NEXT;
      end
      ST_CLAMP_NEXT: begin
        if (past_next) begin
          aoff_nxt = (nexto_r > alen_w) ? nexto_r - alen_w : '0;
        end
        state_nxt = ST_RECLAMP;
      end
      ST_RECLAMP: begin
        if (aoff_r != ooff_w && aoff_r < prevo_r) begin
          aoff_nxt = prevo_r;
        end
        state_nxt = ST_SUM_B;
      end
      ST_SUM_B: begin
        end_nxt   = aoff_r + alen_w;
        state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        if (past_next) begin
          alen_nxt = (nexto_r > aoff_r) ? ALEN_W'(nexto_r - aoff_r) : '0;
        end
        state_nxt = rt_mode_r ? ST_RT_START : ST_DONE;
      end
      ST_RT_START: begin
        div_start    = 1'b1;
        div_dividend = OFF_W'(alen_r);
        div_divisor  = rte;
        state_nxt    = ST_RT_DIV;
      end
      ST_RT_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            state_nxt = ST_DONE;
          end else begin
            rem_nxt   = div_rem;
            end_nxt   = aoff_r + alen_w;
            state_nxt = ST_RT_CHECK;
          end
        end
      end
      ST_RT_CHECK: begin
        if (ooff_w < aoff_r || oend_r > end_r ||
            (alen_r - ALEN_W'(rem_r)) < ALEN_W'(in_r.req_length)) begin
          keep_nxt  = 1'b1;
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RT_ADJUST;
        end
      end
      ST_RT_ADJUST: begin
        if (aoff_r + rem_w <= ooff_w) begin
          alen_nxt  = alen_r - ALEN_W'(rem_r);
          aoff_nxt  = aoff_r + rem_w;
          state_nxt = ST_RT_SUM;
        end else if (end_r - rem_w >= oend_r) begin
          alen_nxt  = alen_r - ALEN_W'(rem_r);
          state_nxt = ST_RT_SUM;
        end else begin
          alen_nxt  = alen_r - ALEN_W'(ooff_w - aoff_r);
          aoff_nxt  = ooff_w;
          state_nxt = ST_RT_START2;
        end
      end
      ST_RT_START2: begin
        div_start    = 1'b1;
        div_dividend = OFF_W'(alen_r);
        div_divisor  = rte;
        state_nxt    = ST_RT_REDIV;
      end
      ST_RT_REDIV: begin
        if (div_done) begin
          alen_nxt  = alen_r - ALEN_W'(div_rem);
          state_nxt = ST_RT_SUM;
        end
      end
      ST_RT_SUM: begin
        end_nxt   = aoff_r + alen_w;
        state_nxt = ST_RT_VERIFY;
      end
      ST_RT_VERIFY: begin
        if (ooff_w < aoff_r || oend_r > end_r) begin
          keep_nxt = 1'b1;
          fail_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (keep_r) begin
            out_data_nxt.aligned_offset = in_r.req_offset;
            out_data_nxt.aligned_length = in_r.req_length;
            out_data_nxt.status         = fail_r;
          end else begin
            out_data_nxt.aligned_offset = aoff_r[OFF_W-1:0];
            out_data_nxt.aligned_length = alen_r[LEN_W-1:0];
            out_data_nxt.status         = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      align_size_r <= LEN_W'(1);
      rt_size_r    <= LEN_W'(1);
      rt_mode_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALIGN_SIZE: align_size_r <= cfg_wdata;
          REG_RT_EXTENT:  rt_size_r    <= cfg_wdata;
          REG_RT_MODE:    rt_mode_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    oend_r     <= oend_nxt;
    nend_r     <= nend_nxt;
    prevo_r    <= prevo_nxt;
    nexto_r    <= nexto_nxt;
    has_next_r <= has_next_nxt;
    aoff_r     <= aoff_nxt;
    alen_r     <= alen_nxt;
    end_r      <= end_nxt;
    rem_r      <= rem_nxt;
    keep_r     <= keep_nxt;
    fail_r     <= fail_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/erq_checker.sv =====
// Port-level checker for the extent request aligner and its bind statement.
module erq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input erq_pkg::erq_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("A stalled result item changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("A new item was taken while one is still being worked on.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("A result item is shown right after reset.");

endmodule

bind extent_request_aligner erq_checker u_erq_checker (.*);
